[design/bfpa_pkg.sv]
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants of the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int NAME_W = 16;
	localparam int SIZE_W = 24;
	localparam int SUM_W  = 32;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef struct packed {
		logic              opcode;
		logic [NAME_W-1:0] part_id;
		logic [SIZE_W-1:0] amount;
		logic [NAME_W-1:0] job_id;
	} in_item_t;

	typedef struct packed {
		logic [NAME_W-1:0] job_tag;
		logic              granted;
		logic [NAME_W-1:0] chosen_part;
		logic [SIZE_W-1:0] waste;
		logic [SUM_W-1:0]  total_waste;
	} out_item_t;

	// Command passed from the front end to the back end through the queue
	typedef struct packed {
		logic              is_alloc;
		logic [NAME_W-1:0] name;
		logic [SIZE_W-1:0] amount;
	} cmd_t;

endpackage

[design/bfpa_ram.sv]
// ----------------------------------------------------------------------------
// bfpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/bfpa_front.sv]
// ----------------------------------------------------------------------------
// bfpa_front
// Accepts input items, classifies them and keeps a two-entry command queue.
// ----------------------------------------------------------------------------
module bfpa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bfpa_pkg::in_item_t  in_data,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output bfpa_pkg::cmd_t      cmd
);

	bfpa_pkg::cmd_t q_q [2];
	logic           rd_q;
	logic           wr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	bfpa_pkg::cmd_t in_cmd;

	// Classify the incoming item
	always_comb begin
		in_cmd.is_alloc = (in_data.opcode == bfpa_pkg::OP_ALLOC);
		in_cmd.name     = in_cmd.is_alloc ? in_data.job_id : in_data.part_id;
		in_cmd.amount   = in_data.amount;
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_q[rd_q];

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= in_cmd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not advance on push");

endmodule

[design/bfpa_back.sv]
// ----------------------------------------------------------------------------
// bfpa_back
// Executes loads and best-fit scans over the partition table.
// ----------------------------------------------------------------------------
module bfpa_back #(
	parameter int MAX_PARTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_take,
	input  bfpa_pkg::cmd_t       cmd,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bfpa_pkg::out_item_t  out_data
);

	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW = $clog2(MAX_PARTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_NAME,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [MAX_PARTS-1:0]           busy_q;
	logic [CW-1:0]                  count_q;
	logic [bfpa_pkg::SUM_W-1:0]     sum_q;
	logic [CW-1:0]                  idx_q;
	logic [IW-1:0]                  rd_idx_q;
	logic [IW-1:0]                  best_q;
	logic [bfpa_pkg::SIZE_W-1:0]    best_w_q;
	logic                           found_q;
	logic [bfpa_pkg::SIZE_W-1:0]    need_q;
	logic [bfpa_pkg::NAME_W-1:0]    job_q;
	logic                           out_valid_q;
	bfpa_pkg::out_item_t            out_q;

	logic                           ram_we;
	logic [IW-1:0]                  ram_raddr;
	logic [bfpa_pkg::SIZE_W-1:0]    size_rd;
	logic [bfpa_pkg::NAME_W-1:0]    name_rd;
	logic                           cand_ok;
	logic [bfpa_pkg::SIZE_W-1:0]    cand_w;
	logic [bfpa_pkg::SUM_W:0]       sum_ext;

	assign cmd_take  = (state_q == ST_IDLE) && (!out_valid_q || !out_stall);
	assign ram_we    = cmd_valid && cmd_take && !cmd.is_alloc
		&& (count_q < CW'(MAX_PARTS));
	assign ram_raddr = (state_q == ST_LAST || state_q == ST_NAME) ? best_q
		: idx_q[IW-1:0];

	bfpa_ram #(.WIDTH(bfpa_pkg::SIZE_W), .DEPTH(MAX_PARTS)) u_sizes (
		.clk(clk), .we(ram_we), .waddr(count_q[IW-1:0]), .wdata(cmd.amount),
		.raddr(ram_raddr), .rdata(size_rd)
	);
	bfpa_ram #(.WIDTH(bfpa_pkg::NAME_W), .DEPTH(MAX_PARTS)) u_names (
		.clk(clk), .we(ram_we), .waddr(count_q[IW-1:0]), .wdata(cmd.name),
		.raddr(ram_raddr), .rdata(name_rd)
	);

	// Compare the entry read last cycle against the best so far
	assign cand_ok = !busy_q[rd_idx_q] && (need_q <= size_rd);
	assign cand_w  = size_rd - need_q;
	assign sum_ext = {1'b0, sum_q} + {{(bfpa_pkg::SUM_W-bfpa_pkg::SIZE_W+1){1'b0}}, best_w_q};

	// Sequence loads and scans, hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_take) begin
						if (!cmd.is_alloc) begin
							if (ram_we) count_q <= count_q + CW'(1);
						end else begin
							need_q  <= cmd.amount;
							job_q   <= cmd.name;
							found_q <= 1'b0;
							idx_q   <= '0;
							state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// idx_q is being read; rd_idx_q is in size_rd
					if (idx_q != '0) begin
						if (cand_ok && (!found_q || cand_w < best_w_q)) begin
							found_q  <= 1'b1;
							best_w_q <= cand_w;
							best_q   <= rd_idx_q;
						end
					end
					rd_idx_q <= idx_q[IW-1:0];
					if (idx_q + CW'(1) == count_q) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_LAST: begin
					if (cand_ok && (!found_q || cand_w < best_w_q)) begin
						found_q  <= 1'b1;
						best_w_q <= cand_w;
						best_q   <= rd_idx_q;
					end
					state_q <= ST_NAME;
				end
				ST_NAME: begin
					// best_q address is read now; data next cycle
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_q.job_tag <= job_q;
					out_q.granted <= found_q;
					if (found_q) begin
						busy_q[best_q]    <= 1'b1;
						out_q.chosen_part <= name_rd;
						out_q.waste       <= best_w_q;
						out_q.total_waste <= sum_ext[bfpa_pkg::SUM_W] ? '1
							: sum_ext[bfpa_pkg::SUM_W-1:0];
						sum_q <= sum_ext[bfpa_pkg::SUM_W] ? '1
							: sum_ext[bfpa_pkg::SUM_W-1:0];
					end else begin
						out_q.chosen_part <= '0;
						out_q.waste       <= '0;
						out_q.total_waste <= sum_q;
					end
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PARTS))
		else $error("partition count beyond table");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |=> (sum_q >= $past(sum_q)))
		else $error("waste sum decreased");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid_q)
		else $error("result not presented");

endmodule

[design/best_fit_partition_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Fixed-partition best-fit allocator, top level.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): opcode load appends a
// partition (part_id, amount) to the table; loads past MAX_PARTS are
// dropped. Opcode allocate scans all loaded entries and grants the free
// partition with least waste, earlier position on a tie.
// Output channel (out_valid/out_stall/out_data): one item per allocate.
// A load passes through the queue to the back end. An allocate reads
// the loaded entries one per table read through a single comparator,
// then reads the chosen name and registers the result.
// A two-entry queue keeps accepting, until it is full, while the back end
// scans or the output is stalled. A stalled result holds in the output
// register; the back end takes no further item until it leaves.
// Reset clears the table count, busy flags and the waste sum.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator #(
	parameter int MAX_PARTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bfpa_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bfpa_pkg::out_item_t  out_data
);

	logic           cmd_valid;
	logic           cmd_take;
	bfpa_pkg::cmd_t cmd;

	bfpa_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	bfpa_back #(.MAX_PARTS(MAX_PARTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
